// File: rtl/pds_pkg.sv
`timescale 1ns / 1ps

package pds_pkg;

	localparam int TILT_W     = 9;
	localparam int ERR_W      = TILT_W + 1;
	localparam int DT_W       = 16;
	localparam int GAIN_W     = 16;
	localparam int LEVEL_W    = 8;
	localparam int DERIV_FRAC = 8;
	// magnitude of (tilt difference << DERIV_FRAC)
	localparam int DIV_NUM_W  = TILT_W + DERIV_FRAC;

	// start clears/loads a serial unit, step advances it by one bit
	typedef struct packed {
		logic start;
		logic step;
	} seq_ctl_t;

endpackage

// File: rtl/pds_smul.sv
`timescale 1ns / 1ps

// Serial-parallel multiplier: the multiplicand stays parallel, the other
// operand enters LSB first, one product bit leaves per step.
module pds_smul import pds_pkg::*; #(
	parameter int MW = 16
) (
	input  logic          clk,
	input  seq_ctl_t      ctl,
	input  logic [MW-1:0] mcand,
	input  logic          bit_in,
	output logic          bit_out
);

	logic [MW:0]   part_q;
	logic [MW+1:0] sum_w;

	assign sum_w   = {part_q[MW], part_q} + (bit_in ? {{2{mcand[MW-1]}}, mcand} : '0);
	assign bit_out = sum_w[0];

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			part_q <= '0;
		end else if (ctl.step) begin
			part_q <= sum_w[MW+1:1];
		end
	end

endmodule

// File: rtl/pds_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per step, DIV_NUM_W steps.
module pds_div import pds_pkg::*; (
	input  logic                 clk,
	input  seq_ctl_t             ctl,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DT_W-1:0]      den,
	output logic [DIV_NUM_W-1:0] quo
);

	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DT_W:0]        shifted;
	logic [DT_W+1:0]      trial;
	logic                 fits;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = ~trial[DT_W+1];
	assign quo     = quo_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (ctl.step) begin
			rem_q <= fits ? trial[DT_W-1:0] : shifted[DT_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

endmodule

// File: rtl/pid_drive_step.sv
`timescale 1ns / 1ps

// One fixed-point PID step per input transfer.
// Input channel (in_valid/in_ready): measured_tilt in degrees and elapsed_ms
// (zero counts as one). Output channel (out_valid/out_ready): drive_level
// 0..255 and clamped, set when the truncated drive fell outside that range.
// Configuration: cfg_write with cfg_index 0..3 writes target_angle, gain_p,
// gain_i, gain_d from cfg_data; write only while no item is in flight.
// Arithmetic is bit serial: the integral add runs over AW = max(SUM_BITS, 26) + 1
// bits (the derivative divider runs alongside it), then the three gain products
// and their sum stream out over TW = SUM_BITS + 24 bits. The state machine steps
// through S_INTEG, S_LOAD, S_TOTAL and S_FIN; in S_FIN the result is loaded into
// the output register once that is free, and the block returns to idle. No new
// item is taken before the result of the last one is loaded.
// in_ready is high only while the block is idle. A result waiting in the
// output register does not block the next input transfer; a finished result
// behind it holds until out_ready frees the register.
// Reset clears state, counter, configuration registers, integral, previous tilt and the output valid flag.
module pid_drive_step import pds_pkg::*; #(
	parameter int SUM_BITS       = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TILT_W-1:0] measured_tilt,
	input  logic [DT_W-1:0]          elapsed_ms,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [LEVEL_W-1:0]       drive_level,
	output logic                     clamped
);

	localparam int PROD_W  = ERR_W + DT_W;
	localparam int AW      = ((SUM_BITS > PROD_W) ? SUM_BITS : PROD_W) + 1;
	localparam int TW      = SUM_BITS + GAIN_W + DERIV_FRAC;
	localparam int F       = GAIN_FRAC_BITS + DERIV_FRAC;
	localparam int CNT_W   = $clog2(TW);
	localparam int DERIV_W = DIV_NUM_W + 1;
	localparam int OPP_W   = ERR_W + DERIV_FRAC;
	localparam int OPI_W   = SUM_BITS + DERIV_FRAC;

	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_GAIN_P = 2'd1;
	localparam logic [1:0] REG_GAIN_I = 2'd2;
	localparam logic [1:0] REG_GAIN_D = 2'd3;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INTEG = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_TOTAL = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TILT_W-1:0]   target_q;
	logic [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic [SUM_BITS-1:0] error_sum_q;
	logic [TILT_W-1:0]   prev_tilt_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  drive_level_q;
	logic                clamped_q;

	logic [TILT_W-1:0]  tilt_q;
	logic [ERR_W-1:0]   err_q;
	logic               neg_q;
	logic [DT_W-1:0]    dt_sh_q;
	logic [AW-1:0]      ext_sh_q, res_sh_q;
	logic               icarry_q;
	logic [OPP_W-1:0]   op_p_q;
	logic [OPI_W-1:0]   op_i_q;
	logic [DERIV_W-1:0] op_d_q;
	logic [1:0]         tcarry_q;
	logic               low_nz_q, hi_ones_q, hi_zero_q, sign_q;
	logic [LEVEL_W-1:0] lvl_sh_q;

	logic                 in_xfer, out_load, last_integ, last_total;
	logic [ERR_W-1:0]     err_w, diff_w, diff_abs;
	logic [DT_W-1:0]      dt_w;
	logic [DIV_NUM_W-1:0] num_w, quo_w;
	logic [DERIV_W-1:0]   deriv_w;
	logic                 ed_bit, ires, icarry_w;
	logic                 p_bit, i_bit, d_bit, tres;
	logic [2:0]           tsum;
	logic [AW-SUM_BITS:0] hi_w;
	logic                 ovf_w;
	logic [SUM_BITS-1:0]  sat_w;
	logic                 fin_clip;
	logic [LEVEL_W-1:0]   fin_level;
	seq_ctl_t             integ_ctl, total_ctl, div_ctl;

	assign in_ready    = (state_q == S_IDLE);
	assign in_xfer     = in_valid & in_ready;
	assign out_load    = (state_q == S_FIN) & (~out_valid_q | out_ready);
	assign last_integ  = (cnt_q == CNT_W'(AW - 1));
	assign last_total  = (cnt_q == CNT_W'(TW - 1));
	assign out_valid   = out_valid_q;
	assign drive_level = drive_level_q;
	assign clamped     = clamped_q;

	// step inputs
	assign err_w    = {measured_tilt[TILT_W-1], measured_tilt} - {target_q[TILT_W-1], target_q};
	assign diff_w   = {measured_tilt[TILT_W-1], measured_tilt}
	                - {prev_tilt_q[TILT_W-1], prev_tilt_q};
	assign diff_abs = diff_w[ERR_W-1] ? (~diff_w + ERR_W'(1)) : diff_w;
	assign num_w    = {diff_abs[TILT_W-1:0], {DERIV_FRAC{1'b0}}};
	assign dt_w     = (elapsed_ms == '0) ? DT_W'(1) : elapsed_ms;

	assign integ_ctl = '{start: in_xfer, step: (state_q == S_INTEG)};
	assign total_ctl = '{start: (state_q == S_LOAD), step: (state_q == S_TOTAL)};
	assign div_ctl   = '{start: in_xfer,
	                     step: (state_q == S_INTEG) && (cnt_q < CNT_W'(DIV_NUM_W))};

	pds_smul #(.MW(ERR_W)) u_mul_ed (
		.clk(clk), .ctl(integ_ctl), .mcand(err_q), .bit_in(dt_sh_q[0]), .bit_out(ed_bit)
	);

	pds_div u_div (
		.clk(clk), .ctl(div_ctl), .num(num_w), .den(dt_w), .quo(quo_w)
	);

	pds_smul #(.MW(GAIN_W)) u_mul_p (
		.clk(clk), .ctl(total_ctl), .mcand(gain_p_q), .bit_in(op_p_q[0]), .bit_out(p_bit)
	);

	pds_smul #(.MW(GAIN_W)) u_mul_i (
		.clk(clk), .ctl(total_ctl), .mcand(gain_i_q), .bit_in(op_i_q[0]), .bit_out(i_bit)
	);

	pds_smul #(.MW(GAIN_W)) u_mul_d (
		.clk(clk), .ctl(total_ctl), .mcand(gain_d_q), .bit_in(op_d_q[0]), .bit_out(d_bit)
	);

	// serial integral add
	assign ires     = ext_sh_q[0] ^ ed_bit ^ icarry_q;
	assign icarry_w = (ext_sh_q[0] & ed_bit) | (ext_sh_q[0] & icarry_q) | (ed_bit & icarry_q);

	// saturate the exact sum to SUM_BITS
	assign hi_w  = res_sh_q[AW-1:SUM_BITS-1];
	assign ovf_w = ~((&hi_w) | ~(|hi_w));
	assign sat_w = ovf_w ? (res_sh_q[AW-1] ? SUM_MIN : SUM_MAX) : res_sh_q[SUM_BITS-1:0];

	assign deriv_w = neg_q ? (~{1'b0, quo_w} + DERIV_W'(1)) : {1'b0, quo_w};

	// three-input serial add of the gain products
	assign tsum = {2'b00, p_bit} + {2'b00, i_bit} + {2'b00, d_bit} + {1'b0, tcarry_q};
	assign tres = tsum[0];

	assign fin_clip  = sign_q ? ~(hi_ones_q & low_nz_q) : ~hi_zero_q;
	assign fin_level = sign_q ? '0 : (hi_zero_q ? lvl_sh_q : '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			target_q    <= '0;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			error_sum_q <= '0;
			prev_tilt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_TARGET: target_q <= cfg_data[TILT_W-1:0];
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					default:    ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_INTEG;
						cnt_q   <= '0;
					end
				end
				S_INTEG: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_integ) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					error_sum_q <= sat_w;
					prev_tilt_q <= tilt_q;
					cnt_q       <= '0;
					state_q     <= S_TOTAL;
				end
				S_TOTAL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_total) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tilt_q   <= measured_tilt;
			err_q    <= err_w;
			neg_q    <= diff_w[ERR_W-1];
			dt_sh_q  <= dt_w;
			ext_sh_q <= {{(AW-SUM_BITS){error_sum_q[SUM_BITS-1]}}, error_sum_q};
			icarry_q <= 1'b0;
		end

		if (state_q == S_INTEG) begin
			dt_sh_q  <= {1'b0, dt_sh_q[DT_W-1:1]};
			ext_sh_q <= {ext_sh_q[AW-1], ext_sh_q[AW-1:1]};
			res_sh_q <= {ires, res_sh_q[AW-1:1]};
			icarry_q <= icarry_w;
		end

		if (state_q == S_LOAD) begin
			op_p_q    <= {err_q, {DERIV_FRAC{1'b0}}};
			op_i_q    <= {sat_w, {DERIV_FRAC{1'b0}}};
			op_d_q    <= deriv_w;
			tcarry_q  <= 2'b00;
			low_nz_q  <= 1'b0;
			hi_ones_q <= 1'b1;
			hi_zero_q <= 1'b1;
			sign_q    <= 1'b0;
		end

		if (state_q == S_TOTAL) begin
			op_p_q   <= {op_p_q[OPP_W-1], op_p_q[OPP_W-1:1]};
			op_i_q   <= {op_i_q[OPI_W-1], op_i_q[OPI_W-1:1]};
			op_d_q   <= {op_d_q[DERIV_W-1], op_d_q[DERIV_W-1:1]};
			tcarry_q <= tsum[2:1];
			sign_q   <= tres;
			// sort each total bit into fraction, level byte or upper part
			if (cnt_q < CNT_W'(F)) begin
				low_nz_q <= low_nz_q | tres;
			end else if (cnt_q < CNT_W'(F + LEVEL_W)) begin
				lvl_sh_q  <= {tres, lvl_sh_q[LEVEL_W-1:1]};
				hi_ones_q <= hi_ones_q & tres;
			end else begin
				hi_ones_q <= hi_ones_q & tres;
				hi_zero_q <= hi_zero_q & ~tres;
			end
		end

		if (out_load) begin
			drive_level_q <= fin_level;
			clamped_q     <= fin_clip;
		end
	end

endmodule
